@@ rtl/wlan_mgmt_frame_ssid_extractor_top_macros.svh @@
// Assertion helpers used by the top-level RTL.
`ifndef WLAN_MGMT_FRAME_SSID_EXTRACTOR_TOP_MACROS_SVH
`define WLAN_MGMT_FRAME_SSID_EXTRACTOR_TOP_MACROS_SVH

// Implication checked in the same cycle.
`define SSIDX_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Implication checked in the cycle after the condition.
`define SSIDX_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ rtl/ssidx_pkg.sv @@
`timescale 1ns / 1ps
package ssidx_pkg;

  localparam int NAME_LIMIT_DEF = 32;
  localparam int ADDR_BYTES     = 18;
  localparam int ADDR_START     = 4;
  localparam int BEACON_BASE    = 36;
  localparam int PROBE_BASE     = 24;
  localparam int POS_MAX        = 127;
  localparam int NAME_BITS_MAX  = 256;
  localparam int IN_W           = 24;
  localparam int OUT_W          = 232;

  localparam logic [1:0] TYPE_MGMT  = 2'd0;
  localparam logic [3:0] SUB_PROBE  = 4'd4;
  localparam logic [3:0] SUB_BEACON = 4'd8;
  localparam logic [1:0] LAST_CHUNK = 2'd3;

  typedef struct packed {
    logic       start;
    logic       fin;
    logic [7:0] data;
    logic [7:0] strength;
    logic [3:0] channel;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  strength;
    logic [3:0]  channel;
    logic [3:0]  subtype;
    logic [47:0] addr_one;
    logic [47:0] addr_two;
    logic [47:0] addr_three;
    logic [4:0]  name_length;
  } hdr_t;

endpackage

@@ rtl/ssidx_parser.sv @@
`timescale 1ns / 1ps
module ssidx_parser
  import ssidx_pkg::*;
#(
  parameter int NAME_LIMIT = NAME_LIMIT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  in_beat_t                beat,
  output logic                    end_hit,
  output hdr_t                    hdr,
  output logic [NAME_LIMIT*8-1:0] name
);

  localparam logic [7:0] LIMIT_B = 8'(NAME_LIMIT);

  logic [6:0] pos_r, pos_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;
  logic [7:0] addr_r [ADDR_BYTES];
  logic [7:0] addr_nxt [ADDR_BYTES];
  logic       elem_ok_r, elem_ok_nxt;
  logic [4:0] len_r, len_nxt;
  logic [7:0] name_r [NAME_LIMIT];
  logic [7:0] name_nxt [NAME_LIMIT];
  logic [7:0] str_r, str_nxt;
  logic [3:0] chan_r, chan_nxt;

  logic [6:0] pos;
  logic [6:0] base;
  logic [6:0] idx;
  logic       beacon;

  function automatic logic wanted(input logic [7:0] ctrl);
    return ctrl[3:2] == TYPE_MGMT && (ctrl[7:4] == SUB_PROBE || ctrl[7:4] == SUB_BEACON);
  endfunction

  always_comb begin
    pos_nxt     = pos_r;
    ctrl_nxt    = ctrl_r;
    addr_nxt    = addr_r;
    elem_ok_nxt = elem_ok_r;
    len_nxt     = len_r;
    name_nxt    = name_r;
    str_nxt     = str_r;
    chan_nxt    = chan_r;
    beacon      = ctrl_r[7:4] == SUB_BEACON;
    base        = beacon ? 7'(BEACON_BASE) : 7'(PROBE_BASE);
    idx         = pos_r - base - 7'd2;
    pos         = pos_r;
    if (beat.start) begin
      pos         = '0;
      addr_nxt    = '{default: '0};
      elem_ok_nxt = 1'b0;
      len_nxt     = '0;
      name_nxt    = '{default: '0};
      str_nxt     = beat.strength;
      chan_nxt    = beat.channel;
    end
    if (pos == 7'd0) begin
      ctrl_nxt = beat.data;
    end else begin
      for (int j = 0; j < ADDR_BYTES; j++) begin
        if (pos == 7'(ADDR_START + j)) addr_nxt[j] = beat.data;
      end
      if (wanted(ctrl_r)) begin
        if (pos == base) begin
          elem_ok_nxt = beacon || beat.data == 8'd0;
        end else if (pos == base + 7'd1) begin
          len_nxt = (elem_ok_r && beat.data != 8'd0 && beat.data < LIMIT_B) ?
                    beat.data[4:0] : 5'd0;
        end else if (pos >= base + 7'd2) begin
          for (int i = 0; i < NAME_LIMIT; i++) begin
            if (idx == 7'(i) && idx < {2'b00, len_r}) name_nxt[i] = beat.data;
          end
        end
      end
    end
    pos_nxt = (pos == 7'(POS_MAX)) ? pos : pos + 7'd1;
  end

  assign end_hit = beat.fin && wanted(ctrl_nxt);

  always_comb begin
    hdr.strength    = str_nxt;
    hdr.channel     = chan_nxt;
    hdr.subtype     = ctrl_nxt[7:4];
    hdr.addr_one    = {addr_nxt[0], addr_nxt[1], addr_nxt[2],
                       addr_nxt[3], addr_nxt[4], addr_nxt[5]};
    hdr.addr_two    = {addr_nxt[6], addr_nxt[7], addr_nxt[8],
                       addr_nxt[9], addr_nxt[10], addr_nxt[11]};
    hdr.addr_three  = {addr_nxt[12], addr_nxt[13], addr_nxt[14],
                       addr_nxt[15], addr_nxt[16], addr_nxt[17]};
    hdr.name_length = len_nxt;
    for (int i = 0; i < NAME_LIMIT; i++) name[i*8 +: 8] = name_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      ctrl_r    <= '0;
      addr_r    <= '{default: '0};
      elem_ok_r <= 1'b0;
      len_r     <= '0;
      name_r    <= '{default: '0};
      str_r     <= '0;
      chan_r    <= '0;
    end else if (step) begin
      pos_r     <= pos_nxt;
      ctrl_r    <= ctrl_nxt;
      addr_r    <= addr_nxt;
      elem_ok_r <= elem_ok_nxt;
      len_r     <= len_nxt;
      name_r    <= name_nxt;
      str_r     <= str_nxt;
      chan_r    <= chan_nxt;
    end
  end

endmodule

@@ rtl/wlan_mgmt_frame_ssid_extractor_top.sv @@
// A frame's last byte passes the input register, then the output run register, before its first result beat.
// Throughput: one frame byte per cycle, except while a last byte waits for the output run;
// each end of a beacon or probe request yields 4 result beats from the output run register.
// A last byte waits in the input register while the previous run still drains.
// Reset: synchronous, active low; clears all parser state, the 32-byte name
// store and the valid flags of both pipeline stages.
`timescale 1ns / 1ps
`include "wlan_mgmt_frame_ssid_extractor_top_macros.svh"
module wlan_mgmt_frame_ssid_extractor_top
  import ssidx_pkg::*;
#(
  parameter int NAME_LIMIT = NAME_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // frame_byte[7:0], signal_strength[15:8], radio_channel[19:16]
  input  logic [IN_W-1:0]  in_tdata,
  // frame_start[0]
  input  logic             in_tuser,
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  // out_strength[7:0], out_channel[11:8], frame_subtype[15:12], address_one[63:16],
  // address_two[111:64], address_three[159:112], name_length[164:160],
  // name_chunk[228:165], zero pad[231:229]
  output logic [OUT_W-1:0] out_tdata,
  // chunk_number[1:0]
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  in_beat_t               in_r;
  logic                   in_valid_r;
  hdr_t                   hdr;
  hdr_t                   hdr_snap_r;
  logic [NAME_LIMIT*8-1:0] name;
  logic [NAME_LIMIT*8-1:0] name_snap_r;
  logic [NAME_BITS_MAX-1:0] name_pad;
  logic                   snap_valid_r;
  logic [1:0]             cnt_r;
  logic                   end_hit;
  logic                   pend;
  logic                   snap_free;
  logic                   adv;
  logic                   step;
  logic                   load_snap;
  logic                   out_beat;

  ssidx_parser #(.NAME_LIMIT(NAME_LIMIT)) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .beat    (in_r),
    .end_hit (end_hit),
    .hdr     (hdr),
    .name    (name)
  );

  assign out_beat  = snap_valid_r && out_tready;
  assign snap_free = !snap_valid_r || (out_tready && cnt_r == LAST_CHUNK);
  assign pend      = in_valid_r && end_hit;
  assign adv       = !pend || snap_free;
  assign step      = in_valid_r && adv;
  assign load_snap = step && end_hit;
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_r.start    <= in_tuser;
      in_r.fin      <= in_tlast;
      in_r.data     <= in_tdata[7:0];
      in_r.strength <= in_tdata[15:8];
      in_r.channel  <= in_tdata[19:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
      cnt_r        <= '0;
    end else if (load_snap) begin
      snap_valid_r <= 1'b1;
      cnt_r        <= '0;
    end else if (out_beat) begin
      if (cnt_r == LAST_CHUNK) snap_valid_r <= 1'b0;
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_snap) begin
      hdr_snap_r  <= hdr;
      name_snap_r <= name;
    end
  end

  assign name_pad   = NAME_BITS_MAX'(name_snap_r);
  assign out_tvalid = snap_valid_r;
  assign out_tuser  = cnt_r;
  assign out_tlast  = cnt_r == LAST_CHUNK;
  assign out_tdata  = {3'b000, name_pad[{cnt_r, 6'b000000} +: 64], hdr_snap_r.name_length,
                       hdr_snap_r.addr_three, hdr_snap_r.addr_two, hdr_snap_r.addr_one,
                       hdr_snap_r.subtype, hdr_snap_r.channel, hdr_snap_r.strength};

  `SSIDX_ASSERT_NEXT(a_run_unbroken, out_beat && cnt_r != LAST_CHUNK, out_tvalid, "run broke early")
  `SSIDX_ASSERT_NEXT(a_chunk_order, out_beat && cnt_r != LAST_CHUNK, out_tuser == 2'($past(cnt_r) + 2'd1), "chunk order")
  `SSIDX_ASSERT_NOW(a_fall_after_last, $fell(out_tvalid), $past(out_tlast && out_tready), "run ended without last")
  `SSIDX_ASSERT_NOW(a_len_bound, out_tvalid, out_tdata[164:160] <= 5'(NAME_LIMIT - 1), "name length bound")
  `SSIDX_ASSERT_NOW(a_end_held, pend && !snap_free, !in_tready, "end byte overran busy run")

endmodule
